// ===== hdl/dominator_tree_solver_unit_defines.svh =====
// Assertion macros shared by the dominator tree solver modules.
`ifndef DOMINATOR_TREE_SOLVER_UNIT_DEFINES_SVH
`define DOMINATOR_TREE_SOLVER_UNIT_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define DTS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define DTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== hdl/dts_pkg.sv =====
// Shared types and constants for the dominator tree solver.
package dts_pkg;
  localparam int unsigned NodeW = 6;
  localparam int unsigned CountW = 7;

  typedef enum logic {
    CMD_APPEND = 1'b0,
    CMD_SOLVE  = 1'b1
  } cmd_t;

  typedef struct packed {
    logic             cmd;
    logic [NodeW-1:0] from_node;
    logic [NodeW-1:0] to_node;
  } in_item_t;

  typedef struct packed {
    logic [NodeW-1:0] node;
    logic [NodeW-1:0] idom;
    logic             defined;
    logic             edges_dropped;
    logic             last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic edge_append;  // append the held request's edge
    logic init;         // clear dominator valid flags, node 0 valid
    logic pass_start;   // v <= 1, changed <= 0
    logic node_start;   // begin scanning edges for current v
    logic edge_step;    // examine edge at edge index (read data ready)
    logic meet_step;    // one phase of a chain step of the intersection
    logic node_commit;  // write candidate for v, advance v
    logic out_load;     // load output register for out index
    logic out_clear;    // clear overflow flag after emission
  } dp_cmd_t;

  // Status back to the controller.
  typedef struct packed {
    logic edges_done;   // edge index reached edge total
    logic meet_busy;    // intersection not yet converged
    logic nodes_done;   // v reached node count
    logic pass_changed;
    logic out_done;     // last node loaded
  } dp_status_t;
endpackage

// ===== hdl/dts_datapath.sv =====
// Datapath of the dominator tree solver: edge memory, dominator table and meet unit.
`include "dominator_tree_solver_unit_defines.svh"
module dts_datapath #(
  parameter int unsigned MAX_NODES = 64,
  parameter int unsigned MAX_EDGES = 256
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [dts_pkg::CountW-1:0] node_count,
  input  dts_pkg::in_item_t      req,
  input  dts_pkg::dp_cmd_t       cmd,
  output dts_pkg::dp_status_t    status,
  output dts_pkg::out_item_t     result
);
  localparam int unsigned EW = $clog2(MAX_EDGES);
  localparam int unsigned TW = $clog2(MAX_EDGES + 1);
  localparam int unsigned NW = dts_pkg::NodeW;
  localparam int unsigned AW = $clog2(MAX_NODES);
  localparam int unsigned LimW = $clog2(2 * MAX_NODES + 2);

  logic [2*NW-1:0] edge_mem [MAX_EDGES];
  logic [2*NW-1:0] edge_rd;
  logic [TW-1:0]   edge_total;
  logic [TW-1:0]   edge_idx;
  logic [NW-1:0]   idom_table [MAX_NODES];
  logic [NW-1:0]   tab_rd;
  logic [AW-1:0]   tab_addr;
  logic [MAX_NODES-1:0] idom_valid;
  logic [dts_pkg::CountW-1:0] n_act;
  logic [dts_pkg::CountW-1:0] v;
  logic            overflow_seen;
  logic            changed;
  logic            have;
  logic [NW-1:0]   cand;
  logic [NW-1:0]   ma, mb;
  logic            meet_act;
  logic            meet_ph;
  logic [LimW-1:0] steps;
  logic [dts_pkg::CountW-1:0] oi;

  always_comb begin
    if (node_count == '0) n_act = dts_pkg::CountW'(1);
    else if (node_count > dts_pkg::CountW'(MAX_NODES)) n_act = dts_pkg::CountW'(MAX_NODES);
    else n_act = node_count;
  end

  logic [NW-1:0] e_from, e_to;
  assign e_from = edge_rd[2*NW-1:NW];
  assign e_to   = edge_rd[NW-1:0];

  logic e_use;
  assign e_use = ({1'b0, e_to} == v) && ({1'b0, e_from} < n_act) &&
                 idom_valid[e_from[$clog2(MAX_NODES)-1:0]];

  logic add_ok;
  assign add_ok = (edge_total < TW'(MAX_EDGES)) &&
                  ({1'b0, req.from_node} < n_act) && ({1'b0, req.to_node} < n_act);

  // Edge memory: registered read at the scan index.
  always_ff @(posedge clk) begin
    if (cmd.edge_append && add_ok) edge_mem[edge_total[EW-1:0]] <= {req.from_node, req.to_node};
    edge_rd <= edge_mem[edge_idx[EW-1:0]];
  end

  // The dominator table has a registered read: the address follows the meet
  // chain while a meet runs, the output index once the passes are over, and
  // the node being scanned otherwise.
  always_comb begin
    if (meet_act) tab_addr = (ma > mb) ? ma[AW-1:0] : mb[AW-1:0];
    else if (v >= n_act) tab_addr = oi[AW-1:0];
    else tab_addr = v[AW-1:0];
  end

  always_ff @(posedge clk) begin
    tab_rd <= idom_table[tab_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_total <= '0;
      overflow_seen <= 1'b0;
      idom_valid <= '0;
      meet_act <= 1'b0;
      meet_ph <= 1'b0;
      edge_idx <= '0;
    end else begin
      if (cmd.edge_append) begin
        if (add_ok) edge_total <= edge_total + TW'(1);
        else overflow_seen <= 1'b1;
      end
      if (cmd.out_clear) overflow_seen <= 1'b0;
      if (cmd.init) begin
        idom_valid <= MAX_NODES'(1);
        idom_table[0] <= '0;
      end
      if (cmd.pass_start) begin
        v <= dts_pkg::CountW'(1);
        changed <= 1'b0;
      end
      if (cmd.node_start) begin
        edge_idx <= '0;
        have <= 1'b0;
      end
      if (cmd.edge_step) begin
        edge_idx <= edge_idx + TW'(1);
        if (e_use) begin
          if (!have) begin
            cand <= e_from;
            have <= 1'b1;
          end else begin
            ma <= e_from;
            mb <= cand;
            steps <= '0;
            meet_act <= 1'b1;
            meet_ph <= 1'b0;
          end
        end
      end
      // A chain step has two phases: the table read, then the move; the bound
      // yields the root.
      if (cmd.meet_step) begin
        if (!meet_ph) begin
          if (ma == mb) begin
            cand <= ma;
            meet_act <= 1'b0;
          end else if (steps == LimW'(2 * MAX_NODES)) begin
            cand <= '0;
            meet_act <= 1'b0;
          end else begin
            meet_ph <= 1'b1;
          end
        end else begin
          meet_ph <= 1'b0;
          steps <= steps + LimW'(1);
          if (ma > mb) ma <= tab_rd;
          else mb <= tab_rd;
        end
      end
      if (cmd.node_commit) begin
        if (have && (!idom_valid[v[$clog2(MAX_NODES)-1:0]] || tab_rd != cand)) begin
          idom_table[v[$clog2(MAX_NODES)-1:0]] <= cand;
          idom_valid[v[$clog2(MAX_NODES)-1:0]] <= 1'b1;
          changed <= 1'b1;
        end
        v <= v + dts_pkg::CountW'(1);
      end
      if (cmd.init) oi <= '0;
      if (cmd.out_load) begin
        result.node <= oi[NW-1:0];
        result.idom <= idom_valid[oi[$clog2(MAX_NODES)-1:0]] ? tab_rd : '0;
        result.defined <= idom_valid[oi[$clog2(MAX_NODES)-1:0]];
        result.edges_dropped <= overflow_seen;
        result.last <= (oi + dts_pkg::CountW'(1) == n_act);
        oi <= oi + dts_pkg::CountW'(1);
      end
    end
  end

  assign status.edges_done   = (edge_idx == edge_total);
  assign status.meet_busy    = meet_act;
  assign status.nodes_done   = (v >= n_act);
  assign status.pass_changed = changed;
  assign status.out_done     = (oi >= n_act);

  `DTS_ASSERT_IMP(a_total_bound, clk, rst, 1'b1, edge_total <= TW'(MAX_EDGES),
    "edge total above capacity")
  `DTS_ASSERT_IMP(a_root_valid, clk, rst, cmd.edge_step, idom_valid[0],
    "root not valid during scan")
  `DTS_ASSERT_NEXT(a_meet_steps, clk, rst, meet_act,
    steps <= LimW'(2 * MAX_NODES), "meet ran past its step bound")
endmodule

// ===== hdl/dts_controller.sv =====
// Controller state machine of the dominator tree solver.
`include "dominator_tree_solver_unit_defines.svh"
module dts_controller #(
  parameter int unsigned MAX_NODES = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_cmd,
  output logic                out_valid,
  input  logic                out_ready,
  input  dts_pkg::dp_status_t status,
  output dts_pkg::dp_cmd_t    cmd
);
  localparam int unsigned PW = $clog2(MAX_NODES + 3);

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_PASS, S_NODE, S_FETCH, S_EDGE, S_MEET, S_COMMIT,
    S_OUT_LOAD, S_OUT_WAIT, S_OUT_END
  } state_t;

  state_t state;
  logic [PW-1:0] passes;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE:     cmd.edge_append = in_valid && (in_cmd == dts_pkg::CMD_APPEND);
      S_INIT:     cmd.init = 1'b1;
      S_PASS:     cmd.pass_start = 1'b1;
      S_NODE:     cmd.node_start = !status.nodes_done;
      S_EDGE:     cmd.edge_step = !status.edges_done;
      S_MEET:     cmd.meet_step = status.meet_busy;
      S_COMMIT:   cmd.node_commit = 1'b1;
      S_OUT_LOAD: cmd.out_load = 1'b1;
      S_OUT_END:  cmd.out_clear = 1'b1;
      default:    cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      passes <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid && in_cmd == dts_pkg::CMD_SOLVE) state <= S_INIT;
        S_INIT: begin
          passes <= '0;
          state <= S_PASS;
        end
        S_PASS: state <= S_NODE;
        S_NODE: begin
          if (status.nodes_done) begin
            passes <= passes + PW'(1);
            if (status.pass_changed && passes + PW'(1) < PW'(MAX_NODES + 2)) state <= S_PASS;
            else state <= S_OUT_LOAD;
          end else state <= S_FETCH;
        end
        S_FETCH: state <= S_EDGE;  // memory read latency
        S_EDGE: begin
          if (status.edges_done) state <= S_COMMIT;
          else state <= S_MEET;
        end
        S_MEET: if (!status.meet_busy) state <= S_FETCH;
        S_COMMIT: state <= S_NODE;
        S_OUT_LOAD: begin
          out_valid <= 1'b1;
          state <= S_OUT_WAIT;
        end
        S_OUT_WAIT: if (out_ready) begin
          out_valid <= 1'b0;
          state <= status.out_done ? S_OUT_END : S_OUT_LOAD;
        end
        S_OUT_END: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  `DTS_ASSERT_IMP(a_out_only_wait, clk, rst, out_valid, state == S_OUT_WAIT,
    "result valid outside output wait")
  `DTS_ASSERT_IMP(a_ready_idle, clk, rst, in_ready, !out_valid,
    "request taken while a result is pending")
  `DTS_ASSERT_IMP(a_pass_bound, clk, rst, 1'b1, passes <= PW'(MAX_NODES + 2),
    "pass count above its bound")
endmodule

// ===== hdl/dominator_tree_solver_unit.sv =====
// Top level of the dominator tree solver.
// Usage:
//   cfg channel: cfg_valid/cfg_ready with cfg_data sets node_count (1..MAX_NODES).
//   in channel: a request with cmd=0 appends edge from_node->to_node and
//   returns nothing; bad or excess edges are dropped and flagged.
//   A request with cmd=1 solves and then emits node_count results, node 0
//   first, with last on the final one.
// Solve: a setup state, then up to MAX_NODES+2 passes; a pass scans each node
//   1..node_count-1 over all stored edges, with meet chain steps between, paced
//   by the single read ports of the edge memory and the dominator table.
//   Each result is held until out_ready, and one closing state follows before
//   the next request is taken.
// Only one request is in work at a time; in_ready is low during a solve.
// Reset clears the edge store count, the dominated flags and the drop flag;
//   node_count returns to 1.
// A stalled receiver holds the current result; the solve waits for it.
module dominator_tree_solver_unit #(
  parameter int unsigned MAX_NODES = 64,
  parameter int unsigned MAX_EDGES = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [dts_pkg::CountW-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  dts_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output dts_pkg::out_item_t         out_data
);
  logic [dts_pkg::CountW-1:0] node_count;
  dts_pkg::dp_cmd_t    cmd;
  dts_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) node_count <= dts_pkg::CountW'(1);
    else if (cfg_valid) node_count <= cfg_data;
  end

  dts_controller #(.MAX_NODES(MAX_NODES)) u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .in_cmd(in_data.cmd),
    .out_valid, .out_ready, .status, .cmd
  );

  dts_datapath #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_dp (
    .clk, .rst, .node_count, .req(in_data), .cmd, .status, .result(out_data)
  );
endmodule
